[src/ift_pkg.sv]
// Package for the IPv4 flow tracker table.
// Holds the status codes, controller states, shared structs and constants.
// No dependencies.
package ift_pkg;

    localparam int FLOW_ENTRIES_DEF = 4096;
    localparam logic [7:0] ENCAP_RESET = 8'd50;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [16:0] ETH_HDR_BYTES = 17'd14;
    localparam logic [16:0] IP_MIN_BYTES = 17'd20;
    localparam logic [16:0] TCP_HDR_BYTES = 17'd20;
    localparam logic [16:0] UDP_HDR_BYTES = 17'd8;
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam logic [3:0] MIN_IHL = 4'd5;

    localparam logic CMD_OBSERVE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam int KEY_W = 104;

    typedef enum logic [2:0] {
        ST_NOT_IPV4  = 3'd0,
        ST_SHORT_IP  = 3'd1,
        ST_BAD_IHL   = 3'd2,
        ST_UPDATED   = 3'd3,
        ST_INSERTED  = 3'd4,
        ST_FULL      = 3'd5,
        ST_FOUND     = 3'd6,
        ST_NOT_FOUND = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_PROBE
    } t_state;

    typedef struct packed {
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [31:0] port_pair;
        logic [7:0]  protocol;
    } t_key;

    // One parsed transaction waiting for the table controller.
    typedef struct packed {
        logic        query;
        logic        reject;
        t_status     reject_status;
        t_key        key;
        logic [15:0] inner_len;
        logic [15:0] outer_len;
        logic [63:0] timestamp;
    } t_job;

    typedef struct packed {
        logic        valid;
        t_key        key;
        logic [31:0] packets;
        logic [63:0] last_seen;
        logic [15:0] max_outer;
        logic [15:0] max_inner;
    } t_entry;

    typedef struct packed {
        t_status     status;
        logic [31:0] packet_count;
        logic [15:0] max_inner_len;
        logic [15:0] max_outer_len;
        logic [63:0] last_stamp;
    } t_result;

endpackage

[src/ipv4_flow_tracker_table.sv]
// IPv4 five-tuple flow table: top level with the stream ports and the overhead register.
// Instantiates ift_parse and ift_table; uses ift_pkg.
//
// After reset the block sweeps the flow memory, one entry a cycle, and clears every entry
// before it takes the first transaction. The controller starts on a transaction once the
// parse stage holds it, the controller is idle and the output register is empty. A header
// that is rejected goes straight to the output register; otherwise the controller probes
// the memory, one registered memory read per cycle, where P is the number of entries
// visited along the linear probe chain. P is 1 or 2 while the table is lightly loaded and
// grows toward FLOW_ENTRIES as it fills. The controller starts the next transaction only
// once the output register is empty; the next one is parsed and held meanwhile.
module ipv4_flow_tracker_table #(
    parameter int FLOW_ENTRIES = ift_pkg::FLOW_ENTRIES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [7:0]   i_cfg_wdata,     // encap_overhead
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // frame_len, ethertype, header_words, ip_protocol, source_address,
    // dest_address, source_port, dest_port, ip_total_len, timestamp_ns
    input  logic [223:0] i_s_tdata,
    input  logic         i_s_tuser,       // command
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // packet_count, max_inner_len, max_outer_len, last seen timestamp
    output logic [127:0] o_m_tdata,
    output logic [2:0]   o_m_tuser        // status
);

    logic             cfg_write;
    logic [7:0]       r_overhead;
    logic             job_valid;
    ift_pkg::t_job    job;
    logic             job_take;
    ift_pkg::t_result res;

    assign cfg_write = i_cfg_we;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_overhead <= ift_pkg::ENCAP_RESET;
        end else if (cfg_write) begin
            r_overhead <= i_cfg_wdata;
        end
    end

    ift_parse u_parse (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_encap_overhead (r_overhead),
        .i_valid          (i_s_tvalid),
        .o_ready          (o_s_tready),
        .i_command        (i_s_tuser),
        .i_frame_len      (i_s_tdata[15:0]),
        .i_ethertype      (i_s_tdata[31:16]),
        .i_header_words   (i_s_tdata[35:32]),
        .i_ip_protocol    (i_s_tdata[43:36]),
        .i_source_address (i_s_tdata[75:44]),
        .i_dest_address   (i_s_tdata[107:76]),
        .i_source_port    (i_s_tdata[123:108]),
        .i_dest_port      (i_s_tdata[139:124]),
        .i_ip_total_len   (i_s_tdata[155:140]),
        .i_timestamp_ns   (i_s_tdata[219:156]),
        .o_job_valid      (job_valid),
        .o_job            (job),
        .i_job_take       (job_take)
    );

    ift_table #(
        .FLOW_ENTRIES (FLOW_ENTRIES)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_take  (job_take),
        .o_res_valid (o_m_tvalid),
        .o_res       (res),
        .i_res_ready (i_m_tready)
    );

    assign o_m_tuser = res.status;
    assign o_m_tdata = {res.last_stamp, res.max_outer_len, res.max_inner_len,
                        res.packet_count};

endmodule

[src/ift_parse.sv]
// Header check and key formation stage of the IPv4 flow tracker table.
// Holds one parsed transaction until the table controller takes it. Uses ift_pkg.
module ift_parse (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [7:0]         i_encap_overhead,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_command,
    input  logic [15:0]        i_frame_len,
    input  logic [15:0]        i_ethertype,
    input  logic [3:0]         i_header_words,
    input  logic [7:0]         i_ip_protocol,
    input  logic [31:0]        i_source_address,
    input  logic [31:0]        i_dest_address,
    input  logic [15:0]        i_source_port,
    input  logic [15:0]        i_dest_port,
    input  logic [15:0]        i_ip_total_len,
    input  logic [63:0]        i_timestamp_ns,
    output logic               o_job_valid,
    output ift_pkg::t_job      o_job,
    input  logic               i_job_take
);

    logic          r_valid;
    ift_pkg::t_job r_job;
    ift_pkg::t_job n_job;
    logic [16:0]   frame17;
    logic [16:0]   l4_start;
    logic [16:0]   thdr;
    logic          ports_ok;

    assign o_ready = !r_valid || i_job_take;
    assign o_job_valid = r_valid;
    assign o_job = r_job;

    always_comb begin
        frame17 = {1'b0, i_frame_len};
        l4_start = ift_pkg::ETH_HDR_BYTES + {11'd0, i_header_words, 2'b00};
        if (i_ip_protocol == ift_pkg::PROTO_TCP) begin
            thdr = ift_pkg::TCP_HDR_BYTES;
        end else if (i_ip_protocol == ift_pkg::PROTO_UDP) begin
            thdr = ift_pkg::UDP_HDR_BYTES;
        end else begin
            thdr = '0;
        end
        ports_ok = (thdr != '0) && ((l4_start + thdr) <= frame17);

        n_job.query = (i_command == ift_pkg::CMD_QUERY);
        n_job.key.source_address = i_source_address;
        n_job.key.dest_address = i_dest_address;
        n_job.key.protocol = i_ip_protocol;
        // A query uses the ports exactly as given.
        if (n_job.query || ports_ok) begin
            n_job.key.port_pair = {i_source_port, i_dest_port};
        end else begin
            n_job.key.port_pair = '0;
        end
        n_job.inner_len = i_ip_total_len;
        n_job.outer_len = i_ip_total_len + {8'd0, i_encap_overhead};
        n_job.timestamp = i_timestamp_ns;

        n_job.reject = 1'b0;
        n_job.reject_status = ift_pkg::ST_NOT_IPV4;
        if (!n_job.query) begin
            if (frame17 < ift_pkg::ETH_HDR_BYTES || i_ethertype != ift_pkg::ETHERTYPE_IPV4) begin
                n_job.reject = 1'b1;
                n_job.reject_status = ift_pkg::ST_NOT_IPV4;
            end else if (frame17 < ift_pkg::ETH_HDR_BYTES + ift_pkg::IP_MIN_BYTES) begin
                n_job.reject = 1'b1;
                n_job.reject_status = ift_pkg::ST_SHORT_IP;
            end else if (i_header_words < ift_pkg::MIN_IHL) begin
                n_job.reject = 1'b1;
                n_job.reject_status = ift_pkg::ST_BAD_IHL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_job <= n_job;
        end
    end

endmodule

[src/ift_table.sv]
// Flow memory and probe controller of the IPv4 flow tracker table.
// Hashed open addressing with linear probing over one synchronous memory. Uses ift_pkg.
module ift_table #(
    parameter int FLOW_ENTRIES = ift_pkg::FLOW_ENTRIES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_job_valid,
    input  ift_pkg::t_job   i_job,
    output logic            o_job_take,
    output logic            o_res_valid,
    output ift_pkg::t_result o_res,
    input  logic            i_res_ready
);

    localparam int IDX_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
    localparam int CNT_W = $clog2(FLOW_ENTRIES + 1);
    localparam logic [CNT_W-1:0] ENTRIES_C = CNT_W'(FLOW_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FLOW_ENTRIES - 1);

    ift_pkg::t_entry r_mem [FLOW_ENTRIES];
    ift_pkg::t_entry r_rd;

    ift_pkg::t_state r_state, n_state;
    logic [IDX_W-1:0] r_addr, n_addr;
    logic [CNT_W-1:0] r_probes, n_probes;
    logic [CNT_W-1:0] r_flows, n_flows;
    logic             r_res_valid, n_res_valid;
    ift_pkg::t_result r_res, n_res;

    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    ift_pkg::t_entry  wr_data;

    logic [IDX_W-1:0] fold;
    logic [IDX_W-1:0] hash;
    logic [IDX_W-1:0] next_addr;
    logic             hit;
    logic             finish;
    ift_pkg::t_entry  upd;

    // Fold the key down to an index, then bring it into the table range.
    always_comb begin
        fold = '0;
        for (int i = 0; i < ift_pkg::KEY_W; i++) begin
            fold[i % IDX_W] = fold[i % IDX_W] ^ i_job.key[i];
        end
        if ({1'b0, fold} >= (IDX_W+1)'(FLOW_ENTRIES)) begin
            hash = fold - LAST_IDX - IDX_W'(1);
        end else begin
            hash = fold;
        end
        next_addr = (r_addr == LAST_IDX) ? '0 : r_addr + IDX_W'(1);
        hit = r_rd.valid && (r_rd.key == i_job.key);
        finish = hit || !r_rd.valid || (r_probes == ENTRIES_C);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ift_pkg::S_CLEAR: begin
                if (r_addr == LAST_IDX) begin
                    n_state = ift_pkg::S_IDLE;
                end
            end
            ift_pkg::S_IDLE: begin
                if (i_job_valid && !r_res_valid && !i_job.reject) begin
                    n_state = ift_pkg::S_PROBE;
                end
            end
            ift_pkg::S_PROBE: begin
                if (finish) begin
                    n_state = ift_pkg::S_IDLE;
                end
            end
            default: n_state = ift_pkg::S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_addr = r_addr;
        n_probes = r_probes;
        n_flows = r_flows;
        n_res = r_res;
        n_res_valid = r_res_valid && !i_res_ready;
        rd_addr = r_addr;
        wr_en = 1'b0;
        wr_addr = r_addr;
        wr_data = '0;
        o_job_take = 1'b0;

        upd = r_rd;
        upd.packets = (r_rd.packets == '1) ? r_rd.packets : r_rd.packets + 32'd1;
        upd.last_seen = i_job.timestamp;
        upd.max_inner = (i_job.inner_len > r_rd.max_inner) ? i_job.inner_len : r_rd.max_inner;
        upd.max_outer = (i_job.outer_len > r_rd.max_outer) ? i_job.outer_len : r_rd.max_outer;

        unique case (r_state)
            ift_pkg::S_CLEAR: begin
                wr_en = 1'b1;
                n_addr = next_addr;
            end
            ift_pkg::S_IDLE: begin
                if (i_job_valid && !r_res_valid) begin
                    if (i_job.reject) begin
                        o_job_take = 1'b1;
                        n_res = '0;
                        n_res.status = i_job.reject_status;
                        n_res_valid = 1'b1;
                    end else begin
                        rd_addr = hash;
                        n_addr = hash;
                        n_probes = CNT_W'(1);
                    end
                end
            end
            ift_pkg::S_PROBE: begin
                if (finish) begin
                    o_job_take = 1'b1;
                    n_res_valid = 1'b1;
                    n_res = '0;
                    if (hit && i_job.query) begin
                        n_res.status = ift_pkg::ST_FOUND;
                        n_res.packet_count = r_rd.packets;
                        n_res.max_inner_len = r_rd.max_inner;
                        n_res.max_outer_len = r_rd.max_outer;
                        n_res.last_stamp = r_rd.last_seen;
                    end else if (hit) begin
                        wr_en = 1'b1;
                        wr_data = upd;
                        n_res.status = ift_pkg::ST_UPDATED;
                        n_res.packet_count = upd.packets;
                        n_res.max_inner_len = upd.max_inner;
                        n_res.max_outer_len = upd.max_outer;
                        n_res.last_stamp = upd.last_seen;
                    end else if (i_job.query) begin
                        n_res.status = ift_pkg::ST_NOT_FOUND;
                    end else if (!r_rd.valid && r_flows < ENTRIES_C) begin
                        wr_en = 1'b1;
                        wr_data.valid = 1'b1;
                        wr_data.key = i_job.key;
                        wr_data.packets = 32'd1;
                        wr_data.last_seen = i_job.timestamp;
                        wr_data.max_inner = i_job.inner_len;
                        wr_data.max_outer = i_job.outer_len;
                        n_flows = r_flows + CNT_W'(1);
                        n_res.status = ift_pkg::ST_INSERTED;
                        n_res.packet_count = 32'd1;
                        n_res.max_inner_len = i_job.inner_len;
                        n_res.max_outer_len = i_job.outer_len;
                        n_res.last_stamp = i_job.timestamp;
                    end else begin
                        n_res.status = ift_pkg::ST_FULL;
                    end
                end else begin
                    rd_addr = next_addr;
                    n_addr = next_addr;
                    n_probes = r_probes + CNT_W'(1);
                end
            end
            default: ;
        endcase
    end

    // The write of a finished transaction lands before the next read is issued,
    // so no forwarding is needed between transactions.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ift_pkg::S_CLEAR;
            r_addr <= '0;
            r_probes <= '0;
            r_flows <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr <= n_addr;
            r_probes <= n_probes;
            r_flows <= n_flows;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_res = r_res;

endmodule

[test/ipv4_flow_tracker_table_tb.sv]
// Self-checking testbench for ipv4_flow_tracker_table.
// Depends on ift_pkg and the block's RTL. A scoreboard class predicts every result
// from the accepted transactions; plain tasks drive the stream and config ports.
`timescale 1ns / 1ps

module ipv4_flow_tracker_table_tb;

    localparam int  LIMIT_CYCLES = 3000000;
    localparam int  RANDOM_ITEMS = 1830;
    localparam int  POOL_SIZE = 48;

    typedef struct {
        logic [31:0] packets;
        logic [63:0] last_seen;
        logic [15:0] max_inner;
        logic [15:0] max_outer;
    } t_flow_rec;

    class flow_scoreboard;
        t_flow_rec            flows[logic [103:0]];
        int                   flow_total;
        logic [7:0]           overhead;
        ift_pkg::t_result     pending_q[$];
        int                   mismatches;

        function new();
            flow_total = 0;
            overhead = ift_pkg::ENCAP_RESET;
            mismatches = 0;
        endfunction

        function void note_item(input logic cmd, input logic [223:0] d);
            logic [15:0] flen, etype, sp, dp, inner, outer;
            logic [3:0]  ihl;
            logic [7:0]  proto;
            logic [31:0] sa, da, ports;
            logic [63:0] ts;
            logic [16:0] thdr;
            logic [103:0] k;
            ift_pkg::t_result r;
            flen = d[15:0]; etype = d[31:16]; ihl = d[35:32]; proto = d[43:36];
            sa = d[75:44]; da = d[107:76]; sp = d[123:108]; dp = d[139:124];
            inner = d[155:140]; ts = d[219:156];
            r = '0;
            if (cmd == ift_pkg::CMD_QUERY) begin
                k = {sa, da, sp, dp, proto};
                if (flows.exists(k)) begin
                    r.status = ift_pkg::ST_FOUND;
                    r.packet_count = flows[k].packets;
                    r.max_inner_len = flows[k].max_inner;
                    r.max_outer_len = flows[k].max_outer;
                    r.last_stamp = flows[k].last_seen;
                end else begin
                    r.status = ift_pkg::ST_NOT_FOUND;
                end
            end else if ({1'b0, flen} < ift_pkg::ETH_HDR_BYTES ||
                         etype != ift_pkg::ETHERTYPE_IPV4) begin
                r.status = ift_pkg::ST_NOT_IPV4;
            end else if ({1'b0, flen} < ift_pkg::ETH_HDR_BYTES + ift_pkg::IP_MIN_BYTES) begin
                r.status = ift_pkg::ST_SHORT_IP;
            end else if (ihl < ift_pkg::MIN_IHL) begin
                r.status = ift_pkg::ST_BAD_IHL;
            end else begin
                thdr = (proto == ift_pkg::PROTO_TCP) ? ift_pkg::TCP_HDR_BYTES :
                       (proto == ift_pkg::PROTO_UDP) ? ift_pkg::UDP_HDR_BYTES : 17'd0;
                ports = '0;
                if (thdr != 17'd0 && ift_pkg::ETH_HDR_BYTES + {11'd0, ihl, 2'b00} + thdr
                        <= {1'b0, flen})
                    ports = {sp, dp};
                outer = inner + {8'd0, overhead};
                k = {sa, da, ports, proto};
                if (flows.exists(k)) begin
                    if (flows[k].packets != 32'hFFFF_FFFF)
                        flows[k].packets++;
                    flows[k].last_seen = ts;
                    if (inner > flows[k].max_inner) flows[k].max_inner = inner;
                    if (outer > flows[k].max_outer) flows[k].max_outer = outer;
                    r.status = ift_pkg::ST_UPDATED;
                end else if (flow_total >= ift_pkg::FLOW_ENTRIES_DEF) begin
                    r.status = ift_pkg::ST_FULL;
                end else begin
                    flows[k] = '{32'd1, ts, inner, outer};
                    flow_total++;
                    r.status = ift_pkg::ST_INSERTED;
                end
                if (r.status != ift_pkg::ST_FULL) begin
                    r.packet_count = flows[k].packets;
                    r.max_inner_len = flows[k].max_inner;
                    r.max_outer_len = flows[k].max_outer;
                    r.last_stamp = flows[k].last_seen;
                end
            end
            pending_q.push_back(r);
        endfunction

        function void check_result(input logic [2:0] status, input logic [127:0] d);
            ift_pkg::t_result want;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d data %h", status, d);
                return;
            end
            want = pending_q.pop_front();
            if (status !== want.status || d[31:0] !== want.packet_count ||
                d[47:32] !== want.max_inner_len || d[63:48] !== want.max_outer_len ||
                d[127:64] !== want.last_stamp) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: expected st %0d cnt %0d in %0d out %0d ts %h,",
                              " got st %0d cnt %0d in %0d out %0d ts %h"},
                        want.status, want.packet_count, want.max_inner_len,
                        want.max_outer_len, want.last_stamp, status, d[31:0],
                        d[47:32], d[63:48], d[127:64]);
            end
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic [7:0]   cfg_wdata = '0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    logic [223:0] s_data = '0;
    logic         s_user = 1'b0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    logic [127:0] m_data;
    logic [2:0]   m_user;

    flow_scoreboard sb = new();
    int  cycle_count = 0;
    bit  no_idle = 1'b0;

    logic [31:0] pool_sa[POOL_SIZE], pool_da[POOL_SIZE];
    logic [15:0] pool_sp[POOL_SIZE], pool_dp[POOL_SIZE];
    logic [7:0]  pool_proto[POOL_SIZE];

    always #10 i_clk = ~i_clk;

    ipv4_flow_tracker_table i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_s_tvalid(s_valid), .o_s_tready(s_ready),
        .i_s_tdata(s_data), .i_s_tuser(s_user),
        .o_m_tvalid(m_valid), .i_m_tready(m_ready),
        .o_m_tdata(m_data), .o_m_tuser(m_user)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("ipv4_flow_tracker_table_tb: FAIL");
            $finish;
        end
        if (m_valid && m_ready)
            sb.check_result(m_user, m_data);
        if (i_rst_n)
            m_ready <= no_idle || ($urandom_range(0, 99) >= 29);
    end

    function automatic logic [223:0] pack_item(input logic [15:0] flen, etype,
            input logic [3:0] ihl, input logic [7:0] proto, input logic [31:0] sa, da,
            input logic [15:0] sp, dp, inner, input logic [63:0] ts);
        return {4'd0, ts, inner, dp, sp, da, sa, proto, ihl, etype, flen};
    endfunction

    // Holds one transaction on the slave side until it is accepted.
    task automatic send_item(input logic cmd, input logic [223:0] d);
        s_valid <= 1'b1;
        s_data <= d;
        s_user <= cmd;
        do @(posedge i_clk); while (!s_ready);
        sb.note_item(cmd, d);
        if (!no_idle && $urandom_range(0, 99) < 29) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic write_overhead(input logic [7:0] value);
        s_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        sb.overhead = value;
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_random_item();
        int           r, p, ihl;
        logic [7:0]   proto;
        logic [15:0]  flen, inner, sp, dp;
        logic [223:0] d;
        r = $urandom_range(0, 99);
        p = $urandom_range(0, POOL_SIZE - 1);
        inner = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(20, 1500));
        if (r < 55) begin
            ihl = $urandom_range(5, 15);
            flen = 16'(14 + 4 * ihl + 20 + $urandom_range(0, 1500));
            if ($urandom_range(0, 9) == 0)
                flen = 16'(14 + 4 * ihl + $urandom_range(0, 19));
            if (flen < 16'd34) flen = 16'd34;
            send_item(ift_pkg::CMD_OBSERVE, pack_item(flen, ift_pkg::ETHERTYPE_IPV4, 4'(ihl),
                pool_proto[p], pool_sa[p], pool_da[p], pool_sp[p], pool_dp[p], inner,
                {$urandom, $urandom}));
        end else if (r < 75) begin
            proto = pool_proto[p];
            sp = (proto == ift_pkg::PROTO_TCP || proto == ift_pkg::PROTO_UDP) ?
                pool_sp[p] : 16'd0;
            dp = (proto == ift_pkg::PROTO_TCP || proto == ift_pkg::PROTO_UDP) ?
                pool_dp[p] : 16'd0;
            send_item(ift_pkg::CMD_QUERY, pack_item(16'($urandom), 16'($urandom),
                4'($urandom), proto, pool_sa[p], pool_da[p], sp, dp, 16'($urandom),
                {$urandom, $urandom}));
        end else if (r < 80) begin
            d = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            d[223:220] = '0;
            send_item(ift_pkg::CMD_QUERY, d);
        end else begin
            d = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            d[223:220] = '0;
            if ($urandom_range(0, 1)) begin
                d[31:16] = ift_pkg::ETHERTYPE_IPV4;
                d[15:0] = 16'($urandom_range(0, 120));
            end
            send_item(ift_pkg::CMD_OBSERVE, d);
        end
        // Occasionally a pool flow is replaced so new flows keep arriving.
        if ($urandom_range(0, 49) == 0) begin
            pool_sa[p] = $urandom;
            pool_da[p] = $urandom;
        end
    endtask

    initial begin
        logic [63:0] all_ones;
        all_ones = '1;
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_sa[i] = $urandom;
            pool_da[i] = $urandom;
            pool_sp[i] = 16'($urandom);
            pool_dp[i] = 16'($urandom);
            pool_proto[i] = (i % 3 == 0) ? ift_pkg::PROTO_TCP :
                            (i % 3 == 1) ? ift_pkg::PROTO_UDP : 8'($urandom);
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: rejects, port rules, queries and field extremes.
        send_item(ift_pkg::CMD_OBSERVE, pack_item(16'd100, 16'h86DD, 4'd5,
            ift_pkg::PROTO_TCP, 1, 2, 3, 4, 60, 1));
        send_item(ift_pkg::CMD_OBSERVE, pack_item(16'd13, ift_pkg::ETHERTYPE_IPV4, 4'd5,
            ift_pkg::PROTO_TCP, 1, 2, 3, 4, 60, 2));
        send_item(ift_pkg::CMD_OBSERVE, pack_item(16'd0, 16'h0000, 4'd0, 8'd0,
            0, 0, 0, 0, 0, 0));
        send_item(ift_pkg::CMD_OBSERVE, pack_item(16'd33, ift_pkg::ETHERTYPE_IPV4, 4'd5,
            ift_pkg::PROTO_TCP, 1, 2, 3, 4, 60, 3));
        send_item(ift_pkg::CMD_OBSERVE, pack_item(16'd34, ift_pkg::ETHERTYPE_IPV4, 4'd4,
            ift_pkg::PROTO_TCP, 1, 2, 3, 4, 60, 4));
        send_item(ift_pkg::CMD_OBSERVE, pack_item(16'd34, ift_pkg::ETHERTYPE_IPV4, 4'd0,
            ift_pkg::PROTO_TCP, 1, 2, 3, 4, 60, 4));
        send_item(ift_pkg::CMD_OBSERVE, pack_item(16'd54, ift_pkg::ETHERTYPE_IPV4, 4'd5,
            ift_pkg::PROTO_TCP, 1, 2, 3, 4, 60, 5));
        send_item(ift_pkg::CMD_OBSERVE, pack_item(16'd53, ift_pkg::ETHERTYPE_IPV4, 4'd5,
            ift_pkg::PROTO_TCP, 1, 2, 3, 4, 70, 6));
        send_item(ift_pkg::CMD_OBSERVE, pack_item(16'd42, ift_pkg::ETHERTYPE_IPV4, 4'd5,
            ift_pkg::PROTO_UDP, 5, 6, 7, 8, 80, 7));
        send_item(ift_pkg::CMD_OBSERVE, pack_item(16'd41, ift_pkg::ETHERTYPE_IPV4, 4'd5,
            ift_pkg::PROTO_UDP, 5, 6, 7, 8, 90, 8));
        send_item(ift_pkg::CMD_OBSERVE, pack_item(16'd500, ift_pkg::ETHERTYPE_IPV4, 4'd15,
            8'd1, 9, 9, 11, 12, 40, 9));
        send_item(ift_pkg::CMD_OBSERVE, pack_item(16'd54, ift_pkg::ETHERTYPE_IPV4, 4'd5,
            ift_pkg::PROTO_TCP, 1, 2, 3, 4, 30, 10));
        send_item(ift_pkg::CMD_QUERY, pack_item(16'd0, 16'd0, 4'd0, ift_pkg::PROTO_TCP,
            1, 2, 3, 4, 0, 0));
        send_item(ift_pkg::CMD_QUERY, pack_item(16'd0, 16'd0, 4'd0, 8'd1,
            9, 9, 11, 12, 0, 0));
        send_item(ift_pkg::CMD_QUERY, pack_item(16'd0, 16'd0, 4'd0, 8'd1,
            9, 9, 0, 0, 0, 0));
        send_item(ift_pkg::CMD_OBSERVE, pack_item(16'hFFFF, ift_pkg::ETHERTYPE_IPV4, 4'hF,
            8'hFF, '1, '1, 16'hFFFF, 16'hFFFF, 16'hFFFF, all_ones));
        send_item(ift_pkg::CMD_OBSERVE, pack_item(16'hFFFF, ift_pkg::ETHERTYPE_IPV4, 4'hF,
            ift_pkg::PROTO_UDP, '1, '1, 16'hFFFF, 16'hFFFF, 16'hFFFF, all_ones));
        send_item(ift_pkg::CMD_QUERY, pack_item(16'hFFFF, 16'hFFFF, 4'hF,
            ift_pkg::PROTO_UDP, '1, '1, 16'hFFFF, 16'hFFFF, 16'hFFFF, all_ones));
        send_item(ift_pkg::CMD_QUERY, pack_item(16'd0, 16'd0, 4'd0, 8'd0,
            0, 0, 0, 0, 0, 0));

        write_overhead(8'd255);
        // The outer length wraps past 16 bits here.
        send_item(ift_pkg::CMD_OBSERVE, pack_item(16'hFFFF, ift_pkg::ETHERTYPE_IPV4, 4'd5,
            ift_pkg::PROTO_UDP, '1, '1, 16'hFFFF, 16'hFFFF, 16'hFFF0, 64'd5));
        send_item(ift_pkg::CMD_OBSERVE, pack_item(16'd60, ift_pkg::ETHERTYPE_IPV4, 4'd5,
            ift_pkg::PROTO_TCP, 1, 2, 3, 4, 65535, 11));

        for (int phase = 0; phase < 4; phase++) begin
            if (phase == 1) write_overhead(8'd0);
            if (phase == 2) write_overhead(8'($urandom));
            if (phase == 3) write_overhead(8'd255);
            for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
                no_idle = (phase == 1 && n > 100 && n < 350);
                send_random_item();
            end
        end
        no_idle = 1'b0;
        s_valid <= 1'b0;

        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("ipv4_flow_tracker_table_tb: PASS");
        end else begin
            $display("ipv4_flow_tracker_table_tb: FAIL");
        end
        $finish;
    end
endmodule
